// File: hdl/aep_pkg.sv
// Shared types, widths and fixed-point constants for the easing progress block.
package aep_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 48;

    localparam int DAMP_W  = 16;   // spring damping, Q4.12
    localparam int U_W     = 16;   // phase, 16 fraction bits of a turn
    localparam int U_NUM_W = 29;   // spring phase dividend, p * 2^(28-F)
    localparam int Z_W     = 17;   // quarter-wave argument, 0..65536
    localparam int MAG_W   = 31;   // Q30 magnitudes, 0..1.0
    localparam int Y_W     = 30;   // exp series argument, Q30
    localparam int EACC_W  = 32;   // exp series accumulator, Q30 up to 2.0
    localparam int K_W     = 4;    // integer part of the 2^-x exponent

    localparam logic [31:0] Q30     = 32'h4000_0000;
    localparam logic [31:0] SC_A    = 32'd1686629713;
    localparam logic [31:0] SC_B    = 32'd693598668;
    localparam logic [31:0] SC_C    = 32'd85569306;
    localparam logic [31:0] SC_D    = 32'd5026995;
    localparam logic [31:0] SC_E    = 32'd172272;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam int SINE_CELLS = 4;
    localparam int EXP_CELLS  = 7;

    // Horner coefficients, innermost first (SC_E seeds the chain)
    localparam logic [31:0] SC_COEF [SINE_CELLS] = '{SC_D, SC_C, SC_B, SC_A};

    typedef enum logic [2:0] {
        CURVE_NONE     = 3'd0,
        CURVE_LINEAR   = 3'd1,
        CURVE_EASE_IN  = 3'd2,
        CURVE_EASE_OUT = 3'd3,
        CURVE_EASE_IO  = 3'd4,
        CURVE_SPRING   = 3'd5
    } curve_t;

    typedef enum logic [1:0] {
        REG_CURVE = 2'd0,
        REG_DELAY = 2'd1,
        REG_RUN   = 2'd2,
        REG_DAMP  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_ZERO   = 2'd1,
        CLS_ONE    = 2'd2
    } cls_t;

endpackage

// File: hdl/aep_div_cell.sv
// One restoring-division step: one quotient bit per cell, registered.
module aep_div_cell #(
    parameter int RW = 16,
    parameter int DW = 16,
    parameter int NW = 16,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [DW-1:0] divisor,
    input  logic          v_in,
    input  logic [RW-1:0] rem_in,
    input  logic [NW-1:0] den_in,
    input  logic [QW-1:0] quo_in,
    input  logic [SW-1:0] side_in,
    output logic          v_out,
    output logic [RW-1:0] rem_out,
    output logic [NW-1:0] den_out,
    output logic [QW-1:0] quo_out,
    output logic [SW-1:0] side_out
);

    logic          v_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [NW-1:0] den_reg, den_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [SW-1:0] side_reg;
    logic [RW:0]   trial;
    logic [RW:0]   dz;
    logic [RW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial    = {rem_in, den_in[NW-1]};
        dz       = (RW+1)'(divisor);
        diff     = trial - dz;
        ge       = (trial >= dz);
        rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
        den_next = {den_in[NW-2:0], 1'b0};
        quo_next = {quo_in[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

// File: hdl/aep_sine_cell.sv
// One Horner step of the quarter-wave sine polynomial.
module aep_sine_cell
    import aep_pkg::*;
#(
    parameter logic [31:0] COEF = 32'd0,
    parameter int          SW   = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             v_in,
    input  logic [MAG_W-1:0] z2_in,
    input  logic [MAG_W-1:0] acc_in,
    input  logic [SW-1:0]    side_in,
    output logic             v_out,
    output logic [MAG_W-1:0] z2_out,
    output logic [MAG_W-1:0] acc_out,
    output logic [SW-1:0]    side_out
);

    logic                 v_reg;
    logic [MAG_W-1:0]     z2_reg;
    logic [MAG_W-1:0]     acc_reg, acc_next;
    logic [SW-1:0]        side_reg;
    logic [2*MAG_W-1:0]   prod;
    logic [31:0]          diff;

    always_comb
    begin
        prod     = z2_in * acc_in;
        diff     = COEF - prod[61:30];
        acc_next = diff[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z2_reg   <= z2_in;
            acc_reg  <= acc_next;
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign z2_out   = z2_reg;
    assign acc_out  = acc_reg;
    assign side_out = side_reg;

endmodule

// File: hdl/aep_exp_cell.sv
// One term of the exp Taylor series: acc = 1 + (y*acc)/n, three registered steps.
module aep_exp_cell
    import aep_pkg::*;
#(
    parameter int unsigned DIVN = 1,
    parameter int          SW   = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              v_in,
    input  logic [Y_W-1:0]    y_in,
    input  logic [EACC_W-1:0] acc_in,
    input  logic [SW-1:0]     side_in,
    output logic              v_out,
    output logic [Y_W-1:0]    y_out,
    output logic [EACC_W-1:0] acc_out,
    output logic [SW-1:0]     side_out
);

    // reciprocal for the constant divide; one correction step fixes it up
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIVN);

    logic              v1_reg, v2_reg, v3_reg;
    logic [Y_W-1:0]    y1_reg, y2_reg, y3_reg;
    logic [SW-1:0]     side1_reg, side2_reg, side3_reg;
    logic [30:0]       w1_reg, w1_next;
    logic [30:0]       w2_reg;
    logic [30:0]       q2_reg, q2_next;
    logic [EACC_W-1:0] acc3_reg, acc3_next;
    logic [61:0]       prod_w;
    logic [63:0]       prod_q;
    logic [33:0]       nq;
    logic [33:0]       rm;
    logic              corr;
    logic [30:0]       qf;

    always_comb
    begin
        prod_w    = y_in * acc_in;
        w1_next   = prod_w[60:30];
        prod_q    = w1_reg * RECIP;
        q2_next   = prod_q[62:32];
        nq        = 34'(q2_reg) * 34'(DIVN);
        rm        = 34'(w2_reg) - nq;
        corr      = (rm >= 34'(DIVN));
        qf        = q2_reg + 31'(corr);
        acc3_next = Q30 + EACC_W'(qf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg    <= y_in;
            side1_reg <= side_in;
            w1_reg    <= w1_next;
            y2_reg    <= y1_reg;
            side2_reg <= side1_reg;
            w2_reg    <= w1_reg;
            q2_reg    <= q2_next;
            y3_reg    <= y2_reg;
            side3_reg <= side2_reg;
            acc3_reg  <= acc3_next;
        end
    end

    assign v_out    = v3_reg;
    assign y_out    = y3_reg;
    assign acc_out  = acc3_reg;
    assign side_out = side3_reg;

endmodule

// File: hdl/animation_easing_progress.sv
// Top level: pipelined easing progress evaluator built as a row of cells.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  input    | in        | in_valid / in_stall | time_now, anim_start
//  output   | out       | out_valid/out_stall | linear_progress, eased_progress
//  config   | in        | APB psel/penable    | curve_type, start_delay,
//           |           |                     | run_length, spring_damping
//
// One transaction enters per cycle and one result leaves per cycle while the output is not stalled.
// Most of the row is the F+1 cell linear divider, the 29 cell phase divider
// and the 7 x 3 stage exp series.
// Reset clears only the valid bits and the configuration (linear, run 300).
// A result held on a stalled output freezes the whole row, so in_stall
// follows out_stall while a result waits; bubbles stay in place.
module animation_easing_progress
    import aep_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input transactions
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_BITS-1:0] time_now,
    input  logic [TIME_BITS-1:0] anim_start,
    // output transactions
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [FRAC_BITS:0]   linear_progress,
    output logic [FRAC_BITS+1:0] eased_progress,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int F       = FRAC_BITS;
    localparam int PW      = F + 1;
    localparam int EW      = F + 3;
    localparam int SPAN_W  = 33;
    localparam int CW      = (TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W;
    localparam int DIV1_N  = PW;
    localparam int DIV2_N  = U_NUM_W;
    localparam logic [PW-1:0] ONE  = PW'(1) << F;
    localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);
    localparam logic [EW-1:0] TWO  = EW'(1) << (F + 1);

    typedef struct packed {
        cls_t          cls;
        logic [PW-1:0] p;
        logic [PW-1:0] e_in;
        logic [PW-1:0] e_out;
    } mid_t;

    typedef struct packed {
        mid_t             mid;
        logic             neg;
        logic [K_W-1:0]   k;
        logic [Y_W-1:0]   y;
        logic [Z_W-1:0]   z;
    } ustage_t;

    typedef struct packed {
        mid_t             mid;
        logic             neg;
        logic [K_W-1:0]   k;
        logic [Y_W-1:0]   y;
        logic [MAG_W-1:0] z30;
    } sin_side_t;

    typedef struct packed {
        mid_t             mid;
        logic             neg;
        logic [K_W-1:0]   k;
        logic [MAG_W-1:0] mag;
    } exp_side_t;

    typedef struct packed {
        mid_t             mid;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] tm;
    } kstage_t;

    localparam int MSW = $bits(mid_t);
    localparam int SSW = $bits(sin_side_t);
    localparam int XSW = $bits(exp_side_t);

    // ---------------- configuration registers ----------------
    logic [2:0]        curve_type_reg;
    logic [31:0]       start_delay_reg;
    logic [31:0]       run_length_reg;
    logic [DAMP_W-1:0] spring_damping_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_type_reg     <= CURVE_LINEAR;
            start_delay_reg    <= 32'd0;
            run_length_reg     <= 32'd300;
            spring_damping_reg <= 16'd2048;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_CURVE: curve_type_reg     <= pwdata[2:0];
                REG_DELAY: start_delay_reg    <= pwdata;
                REG_RUN:   run_length_reg     <= pwdata;
                REG_DAMP:  spring_damping_reg <= pwdata[DAMP_W-1:0];
                default:   curve_type_reg     <= curve_type_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_CURVE: prdata = 32'(curve_type_reg);
            REG_DELAY: prdata = start_delay_reg;
            REG_RUN:   prdata = run_length_reg;
            REG_DAMP:  prdata = 32'(spring_damping_reg);
            default:   prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    // The whole row moves together; it only halts while a result is refused.
    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------- stage 0: elapsed time, classification ----------------
    logic [TIME_BITS-1:0] el_full;
    logic [CW-1:0]        el_x, span_x, dly_x;
    logic [SPAN_W-1:0]    span;
    logic [33:0]          num;
    logic                 lt, done, early;
    cls_t                 cls_in;

    always_comb
    begin
        el_full = time_now - anim_start;
        span    = SPAN_W'(start_delay_reg) + SPAN_W'(run_length_reg);
        el_x    = CW'(el_full);
        span_x  = CW'(span);
        dly_x   = CW'(start_delay_reg);
        lt      = (time_now < anim_start);
        done    = (el_x >= span_x);
        early   = (el_x < dly_x);
        // el is below span whenever the item is not forced, so 33 bits hold it
        num     = {1'b0, el_x[SPAN_W-1:0]} + 34'(start_delay_reg);
        if (curve_type_reg == CURVE_NONE)
        begin
            cls_in = CLS_ONE;
        end
        else if (lt)
        begin
            cls_in = CLS_ZERO;
        end
        else if (done)
        begin
            cls_in = CLS_ONE;
        end
        else if (early)
        begin
            cls_in = CLS_ZERO;
        end
        else
        begin
            cls_in = CLS_NORMAL;
        end
    end

    logic              s0_v_reg;
    cls_t              s0_cls_reg;
    logic [SPAN_W-1:0] s0_rem_reg;
    logic [PW-1:0]     s0_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= in_valid;
        end
    end

    // long division of num * 2^F by span: quotient fits F+1 bits since num < 2*span
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_cls_reg <= cls_in;
            s0_rem_reg <= num[33:1];
            s0_den_reg <= {num[0], {F{1'b0}}};
        end
    end

    // ---------------- linear divider row ----------------
    logic              d1_v    [0:DIV1_N];
    logic [SPAN_W-1:0] d1_rem  [0:DIV1_N];
    logic [PW-1:0]     d1_den  [0:DIV1_N];
    logic [PW-1:0]     d1_quo  [0:DIV1_N];
    logic [1:0]        d1_side [0:DIV1_N];

    assign d1_v[0]    = s0_v_reg;
    assign d1_rem[0]  = s0_rem_reg;
    assign d1_den[0]  = s0_den_reg;
    assign d1_quo[0]  = '0;
    assign d1_side[0] = s0_cls_reg;

    for (genvar i = 0; i < DIV1_N; i++)
    begin : g_div1
        aep_div_cell #(
            .RW (SPAN_W),
            .DW (SPAN_W),
            .NW (PW),
            .QW (PW),
            .SW (2)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .divisor  (span),
            .v_in     (d1_v[i]),
            .rem_in   (d1_rem[i]),
            .den_in   (d1_den[i]),
            .quo_in   (d1_quo[i]),
            .side_in  (d1_side[i]),
            .v_out    (d1_v[i+1]),
            .rem_out  (d1_rem[i+1]),
            .den_out  (d1_den[i+1]),
            .quo_out  (d1_quo[i+1]),
            .side_out (d1_side[i+1])
        );
    end

    // ---------------- P stage: saturate, squares for ease in/out ----------------
    logic [PW-1:0]   p_c, tq_c;
    logic [2*PW-1:0] sq_in, sq_out;
    mid_t            mid_c;

    always_comb
    begin
        p_c         = (d1_quo[DIV1_N] > ONE) ? ONE : d1_quo[DIV1_N];
        tq_c        = ONE - p_c;
        sq_in       = (p_c * p_c) + (2*PW)'(HALF);
        sq_out      = (tq_c * tq_c) + (2*PW)'(HALF);
        mid_c.cls   = cls_t'(d1_side[DIV1_N]);
        mid_c.p     = p_c;
        mid_c.e_in  = PW'(sq_in >> F);
        mid_c.e_out = ONE - PW'(sq_out >> F);
    end

    logic p_v_reg;
    mid_t p_mid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p_v_reg <= d1_v[DIV1_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_mid_reg <= mid_c;
        end
    end

    // ---------------- spring phase divider row ----------------
    // u = floor(p * 2^(28-F) / damping), low 16 bits kept
    logic [DAMP_W-1:0]  dm;
    logic               d2_v    [0:DIV2_N];
    logic [DAMP_W-1:0]  d2_rem  [0:DIV2_N];
    logic [U_NUM_W-1:0] d2_den  [0:DIV2_N];
    logic [U_W-1:0]     d2_quo  [0:DIV2_N];
    logic [MSW-1:0]     d2_side [0:DIV2_N];

    assign dm         = (spring_damping_reg == '0) ? DAMP_W'(1) : spring_damping_reg;
    assign d2_v[0]    = p_v_reg;
    assign d2_rem[0]  = '0;
    assign d2_den[0]  = {p_mid_reg.p, {(28 - F){1'b0}}};
    assign d2_quo[0]  = '0;
    assign d2_side[0] = p_mid_reg;

    for (genvar i = 0; i < DIV2_N; i++)
    begin : g_div2
        aep_div_cell #(
            .RW (DAMP_W),
            .DW (DAMP_W),
            .NW (U_NUM_W),
            .QW (U_W),
            .SW (MSW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .divisor  (dm),
            .v_in     (d2_v[i]),
            .rem_in   (d2_rem[i]),
            .den_in   (d2_den[i]),
            .quo_in   (d2_quo[i]),
            .side_in  (d2_side[i]),
            .v_out    (d2_v[i+1]),
            .rem_out  (d2_rem[i+1]),
            .den_out  (d2_den[i+1]),
            .quo_out  (d2_quo[i+1]),
            .side_out (d2_side[i+1])
        );
    end

    // ---------------- U stage: phase fold, exp argument ----------------
    mid_t            u_mid;
    logic [PW+14:0]  u_io_w;
    logic [U_W-1:0]  u16;
    logic [13:0]     rr;
    logic [14:0]     rinv;
    logic [PW+3:0]   tenp;
    logic [PW+19:0]  x16w;
    logic [16:0]     gg;
    logic [46:0]     yprod;
    ustage_t         u_c;

    always_comb
    begin
        u_mid   = mid_t'(d2_side[DIV2_N]);
        u_io_w  = {u_mid.p, 15'b0} >> F;
        u16     = (curve_type_reg == CURVE_SPRING) ? d2_quo[DIV2_N] : u_io_w[U_W-1:0];
        rr      = u16[13:0];
        rinv    = 15'd16384 - {1'b0, rr};
        u_c.mid = u_mid;
        // quadrants 1 and 2 are negative; quadrants 0 and 2 mirror the quarter wave
        u_c.neg = u16[15] ^ u16[14];
        u_c.z   = u16[14] ? {1'b0, rr, 2'b00} : {rinv, 2'b00};
        // 2^(-10p): integer part shifts, fraction feeds the exp series
        tenp    = (PW+4)'(u_mid.p) * (PW+4)'(10);
        x16w    = {tenp, 16'b0} >> F;
        u_c.k   = x16w[19:16];
        gg      = 17'h10000 - {1'b0, x16w[15:0]};
        yprod   = 47'(gg) * 47'(LN2_Q30);
        u_c.y   = yprod[45:16];
    end

    logic    u_v_reg;
    ustage_t u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_v_reg <= 1'b0;
        end
        else if (en)
        begin
            u_v_reg <= d2_v[DIV2_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= u_c;
        end
    end

    // ---------------- Z stage: z^2 ----------------
    logic [MAG_W-1:0]   z30_c;
    logic [2*MAG_W-1:0] z2p;
    sin_side_t          z_side_c;

    always_comb
    begin
        z30_c        = {u_reg.z, 14'b0};
        z2p          = z30_c * z30_c;
        z_side_c.mid = u_reg.mid;
        z_side_c.neg = u_reg.neg;
        z_side_c.k   = u_reg.k;
        z_side_c.y   = u_reg.y;
        z_side_c.z30 = z30_c;
    end

    logic             z_v_reg;
    logic [MAG_W-1:0] z_z2_reg;
    sin_side_t        z_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_v_reg <= 1'b0;
        end
        else if (en)
        begin
            z_v_reg <= u_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_z2_reg   <= z2p[60:30];
            z_side_reg <= z_side_c;
        end
    end

    // ---------------- sine Horner row ----------------
    logic             sn_v    [0:SINE_CELLS];
    logic [MAG_W-1:0] sn_z2   [0:SINE_CELLS];
    logic [MAG_W-1:0] sn_acc  [0:SINE_CELLS];
    logic [SSW-1:0]   sn_side [0:SINE_CELLS];

    assign sn_v[0]    = z_v_reg;
    assign sn_z2[0]   = z_z2_reg;
    assign sn_acc[0]  = SC_E[MAG_W-1:0];
    assign sn_side[0] = z_side_reg;

    for (genvar i = 0; i < SINE_CELLS; i++)
    begin : g_sine
        aep_sine_cell #(
            .COEF (SC_COEF[i]),
            .SW   (SSW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (sn_v[i]),
            .z2_in    (sn_z2[i]),
            .acc_in   (sn_acc[i]),
            .side_in  (sn_side[i]),
            .v_out    (sn_v[i+1]),
            .z2_out   (sn_z2[i+1]),
            .acc_out  (sn_acc[i+1]),
            .side_out (sn_side[i+1])
        );
    end

    // ---------------- R stage: final sine product, clamp to 1.0 ----------------
    sin_side_t          r_sin;
    logic [2*MAG_W-1:0] rp;
    logic [31:0]        rsh;
    exp_side_t          r_side_c;

    always_comb
    begin
        r_sin        = sin_side_t'(sn_side[SINE_CELLS]);
        rp           = r_sin.z30 * sn_acc[SINE_CELLS];
        rsh          = rp[61:30];
        r_side_c.mid = r_sin.mid;
        r_side_c.neg = r_sin.neg;
        r_side_c.k   = r_sin.k;
        r_side_c.mag = (rsh > Q30) ? Q30[MAG_W-1:0] : rsh[MAG_W-1:0];
    end

    logic           r_v_reg;
    logic [Y_W-1:0] r_y_reg;
    exp_side_t      r_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg <= 1'b0;
        end
        else if (en)
        begin
            r_v_reg <= sn_v[SINE_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_y_reg    <= r_sin.y;
            r_side_reg <= r_side_c;
        end
    end

    // ---------------- exp series row, n = 7 down to 1 ----------------
    logic              ex_v    [0:EXP_CELLS];
    logic [Y_W-1:0]    ex_y    [0:EXP_CELLS];
    logic [EACC_W-1:0] ex_acc  [0:EXP_CELLS];
    logic [XSW-1:0]    ex_side [0:EXP_CELLS];

    assign ex_v[0]    = r_v_reg;
    assign ex_y[0]    = r_y_reg;
    assign ex_acc[0]  = Q30;
    assign ex_side[0] = r_side_reg;

    for (genvar i = 0; i < EXP_CELLS; i++)
    begin : g_exp
        aep_exp_cell #(
            .DIVN (EXP_CELLS - i),
            .SW   (XSW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (ex_v[i]),
            .y_in     (ex_y[i]),
            .acc_in   (ex_acc[i]),
            .side_in  (ex_side[i]),
            .v_out    (ex_v[i+1]),
            .y_out    (ex_y[i+1]),
            .acc_out  (ex_acc[i+1]),
            .side_out (ex_side[i+1])
        );
    end

    // ---------------- K stage: 2^(1-f) >> (1+k), times cosine ----------------
    exp_side_t          k_x;
    logic [EACC_W-1:0]  tsh;
    logic [2*MAG_W-1:0] tmp;
    kstage_t            k_c;

    always_comb
    begin
        k_x     = exp_side_t'(ex_side[EXP_CELLS]);
        tsh     = ex_acc[EXP_CELLS] >> (5'(k_x.k) + 5'd1);
        tmp     = tsh[MAG_W-1:0] * k_x.mag;
        k_c.mid = k_x.mid;
        k_c.neg = k_x.neg;
        k_c.mag = k_x.mag;
        k_c.tm  = tmp[60:30];
    end

    logic    k_v_reg;
    kstage_t k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_v_reg <= 1'b0;
        end
        else if (en)
        begin
            k_v_reg <= ex_v[EXP_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg <= k_c;
        end
    end

    // ---------------- output stage: curve select, rounding, caps ----------------
    logic [32:0]   v_io, v_sp, r_io, r_sp;
    logic [EW-1:0] e_io, e_sp, e_sel, e_cap;
    logic [PW-1:0] lin_next;
    logic [F+1:0]  eased_next;

    always_comb
    begin
        v_io  = k_reg.neg ? 33'(Q30) + 33'(k_reg.mag) : 33'(Q30) - 33'(k_reg.mag);
        v_sp  = k_reg.neg ? 33'(Q30) + 33'(k_reg.tm) : 33'(Q30) - 33'(k_reg.tm);
        r_io  = (v_io + (33'(1) << (30 - F))) >> (31 - F);
        r_sp  = (v_sp + (33'(1) << (29 - F))) >> (30 - F);
        e_io  = r_io[EW-1:0];
        e_sp  = r_sp[EW-1:0];
        case (curve_t'(curve_type_reg))
            CURVE_EASE_IN:  e_sel = EW'(k_reg.mid.e_in);
            CURVE_EASE_OUT: e_sel = EW'(k_reg.mid.e_out);
            CURVE_EASE_IO:  e_sel = e_io;
            CURVE_SPRING:   e_sel = e_sp;
            default:        e_sel = EW'(k_reg.mid.p);
        endcase
        e_cap = (e_sel > TWO) ? TWO : e_sel;
        case (k_reg.mid.cls)
            CLS_ONE:
            begin
                lin_next   = ONE;
                eased_next = (F+2)'(ONE);
            end
            CLS_ZERO:
            begin
                lin_next   = '0;
                eased_next = '0;
            end
            default:
            begin
                lin_next   = k_reg.mid.p;
                eased_next = e_cap[F+1:0];
            end
        endcase
    end

    logic [PW-1:0] lin_reg;
    logic [F+1:0]  eased_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= k_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg   <= lin_next;
            eased_reg <= eased_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign linear_progress = lin_reg;
    assign eased_progress  = eased_reg;

`ifndef NO_ASSERTIONS
    // an accepted transaction lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> d1_v[0])
        else $error("accepted transaction missing from first stage");

    // a refused result freezes the row behind it
    a_row_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(k_v_reg) && $stable(ex_v[0])
                                      && $stable(d2_v[0])))
        else $error("pipeline moved while output stalled");

    // results stay in their ranges
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((linear_progress <= ONE) && (EW'(eased_progress) <= TWO)))
        else $error("result out of range");
`endif

endmodule
